// ----- sv/caldec_pkg.sv -----
// ----------------------------------------------------------------------------
// caldec_pkg
// Shared types, codes and the log table builder of the digit calibrator.
// ----------------------------------------------------------------------------
package caldec_pkg;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_DIGIT = 1'b1;

  localparam logic REG_ENERGY_CUT = 1'b0;
  localparam logic REG_TIME_CUT   = 1'b1;

  localparam logic [30:0] ENERGY_CUT_RESET = 31'd10000;
  localparam logic [14:0] TIME_CUT_RESET   = 15'd100;

  localparam logic [13:0] COUNT_MAX = 14'd16383;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [13:0]        cell_id;
    logic               bad;
    logic signed [18:0] amplitude;
    logic signed [15:0] time_fit;
    logic               last;
    logic [23:0]        gain;
    logic signed [17:0] nonlin;
  } digit_t;

  typedef struct packed {
    logic [30:0] energy_cut;
    logic [14:0] time_cut;
  } cuts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOG, ST_LN, ST_FAC, ST_PROD, ST_MUL, ST_SUM, ST_EMIT
  } back_state_t;

  // log2(1 + i / 2^bits) in Q.16 by repeated squaring
  function automatic logic [16:0] log_entry(input int i, input int bits);
    logic [63:0] y;
    logic [16:0] acc;
    logic [17:0] rnd;
    y   = (64'd1 << 30) + (64'(i) << (30 - bits));
    acc = '0;
    for (int k = 0; k < 17; k++) begin
      y   = (y * y) >> 30;
      acc = {acc[15:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        acc[0] = 1'b1;
        y      = y >> 1;
      end
    end
    rnd = 18'(acc) + 18'd1;
    return rnd[17:1];
  endfunction

endpackage

// ----- sv/caldec_if.sv -----
// ----------------------------------------------------------------------------
// caldec_if
// Request channels of the digit calibrator: input items and result items.
// ----------------------------------------------------------------------------
interface caldec_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [13:0]        cell_id;
  logic signed [18:0] amplitude;
  logic signed [15:0] time_fit;
  logic [23:0]        coef_gain;
  logic signed [17:0] coef_nonlin;
  logic               last_in_event;

  modport source (output valid, func, cell_id, amplitude, time_fit, coef_gain,
                  coef_nonlin, last_in_event, input ready);
  modport sink (input valid, func, cell_id, amplitude, time_fit, coef_gain,
                coef_nonlin, last_in_event, output ready);
endinterface

interface caldec_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        cell_id_out;
  logic signed [31:0] energy_kev;
  logic signed [15:0] time_out;
  logic               cell_error;
  logic               event_done;
  logic [13:0]        background_count;

  modport source (output valid, cell_id_out, energy_kev, time_out, cell_error,
                  event_done, background_count, input ready);
  modport sink (input valid, cell_id_out, energy_kev, time_out, cell_error,
                event_done, background_count, output ready);
endinterface

// ----- sv/caldec_front.sv -----
// ----------------------------------------------------------------------------
// caldec_front
// Accepts requests, writes coefficient loads, looks up coefficients of digits.
// ----------------------------------------------------------------------------
module caldec_front import caldec_pkg::*; #(
  parameter int CELL_COUNT = 8736
) (
  input  logic              clk,
  input  logic              rst_n,
  caldec_in_if.sink         in_ch,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output digit_t            push_data
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  logic [41:0]   mem [CELL_COUNT];
  logic          accept;
  logic          bad;
  logic [13:0]   cell_m1;
  logic [AW-1:0] addr;
  logic          pend_r;
  digit_t        pend_d_r;
  logic [41:0]   rd_r;

  // one slot is held back for a digit whose lookup is in flight
  assign in_ch.ready = (QCNT_W'(q_count) + QCNT_W'(pend_r)) < QCNT_W'(QDEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign bad         = (in_ch.cell_id == 14'd0) || (32'(in_ch.cell_id) > CELL_COUNT);
  assign cell_m1     = in_ch.cell_id - 14'd1;
  assign addr        = cell_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && !bad) begin
      if (in_ch.func == FUNC_LOAD) begin
        mem[addr] <= {in_ch.coef_gain, in_ch.coef_nonlin};
      end else begin
        rd_r <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept && (in_ch.func == FUNC_DIGIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_d_r.cell_id   <= in_ch.cell_id;
      pend_d_r.bad       <= bad;
      pend_d_r.amplitude <= in_ch.amplitude;
      pend_d_r.time_fit  <= in_ch.time_fit;
      pend_d_r.last      <= in_ch.last_in_event;
      pend_d_r.gain      <= '0;
      pend_d_r.nonlin    <= '0;
    end
  end

  always_comb begin
    push_data        = pend_d_r;
    push_data.gain   = rd_r[41:18];
    push_data.nonlin = signed'(rd_r[17:0]);
  end

  assign push = pend_r;

endmodule

// ----- sv/caldec_fifo.sv -----
// ----------------------------------------------------------------------------
// caldec_fifo
// Short queue of looked-up digits between the front and the back.
// ----------------------------------------------------------------------------
module caldec_fifo import caldec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  digit_t            push_data,
  input  logic              pop,
  output digit_t            head,
  output logic              head_valid,
  output logic [QCNT_W-1:0] count
);

  digit_t              q_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r;
  logic [QPTR_W-1:0]   rp_r;
  logic [QCNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop)  rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head       = q_r[rp_r];
  assign head_valid = cnt_r != '0;
  assign count      = cnt_r;

endmodule

// ----- sv/caldec_back.sv -----
// ----------------------------------------------------------------------------
// caldec_back
// Sequencer that calibrates one digit at a time and counts background hits.
// ----------------------------------------------------------------------------
module caldec_back import caldec_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  digit_t       head,
  input  logic         head_valid,
  output logic         pop,
  input  cuts_t        cuts,
  caldec_out_if.source out_ch
);

  localparam int FRAC_SHIFT = 18 - LOG_TABLE_BITS;
  localparam int ENTRIES    = (1 << LOG_TABLE_BITS) + 1;

  logic [16:0] rom [ENTRIES];
  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    assign rom[g] = log_entry(g, LOG_TABLE_BITS);
  end

  back_state_t st_r, st_nxt;

  digit_t             dig_r;
  logic [18:0]        mag_r;
  logic [4:0]         e_r;
  logic [17:0]        f_r;
  logic               small_r;
  logic [21:0]        l2_r;
  logic [21:0]        ln_r;
  logic               fneg_r;
  logic [22:0]        fmag_r;
  logic [42:0]        p_r;
  logic [54:0]        lo_r;
  logic [33:0]        hi_r;
  logic signed [31:0] energy_r;
  logic [13:0]        cnt_r;

  logic               out_valid_r;
  logic [13:0]        out_cell_r;
  logic signed [31:0] out_energy_r;
  logic signed [15:0] out_time_r;
  logic               out_err_r;
  logic               out_done_r;
  logic [13:0]        out_count_r;

  logic [18:0]               mag_c;
  logic [4:0]                e_c;
  logic [17:0]               f_c;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [LOG_TABLE_BITS:0]   idx1;
  logic [FRAC_SHIFT-1:0]     rfrac;
  logic [16:0]               t0, t1, d;
  logic [16+FRAC_SHIFT:0]    dr;
  logic [21:0]               l2_c;
  logic [63:0]               ln_prod;
  logic signed [40:0]        x_c;
  logic signed [40:0]        xr_c;
  logic signed [24:0]        fac_c;
  logic [34:0]               m_c;
  logic                      neg_c;
  logic signed [31:0]        energy_c;
  logic                      slot_free;
  logic                      emit;
  logic [15:0]               atime;
  logic                      hit;
  logic [13:0]               cnt_inc;

  // digit front end: magnitude, exponent and normalized fraction
  always_comb begin
    mag_c = head.amplitude[18] ? 19'(-head.amplitude) : 19'(head.amplitude);
    e_c   = '0;
    for (int k = 1; k < 19; k++) begin
      if (mag_c[k]) e_c = 5'(k);
    end
    f_c = 18'(mag_c << (5'd18 - e_c));
  end

  // table interpolation
  always_comb begin
    idx   = f_r[17 -: LOG_TABLE_BITS];
    idx1  = {1'b0, idx} + (LOG_TABLE_BITS+1)'(1);
    rfrac = f_r[FRAC_SHIFT-1:0];
    t0    = rom[{1'b0, idx}];
    t1    = rom[idx1];
    d     = (t1 > t0) ? (t1 - t0) : 17'd0;
    dr    = (17+FRAC_SHIFT)'(d) * (17+FRAC_SHIFT)'(rfrac);
    l2_c  = {1'b0, e_r, 16'd0} + 22'(t0) + 22'(dr >> FRAC_SHIFT);
  end

  assign ln_prod = 64'(l2_r) * 64'(LN2_Q32);

  always_comb begin
    x_c   = 41'(dig_r.nonlin) * signed'({19'd0, ln_r});
    xr_c  = x_c + 41'sd32768;
    fac_c = 25'sd65536 + 25'(xr_c >>> 16);
  end

  always_comb begin
    m_c   = 35'(hi_r) + 35'((lo_r + 55'h0_8000_0000) >> 32);
    neg_c = dig_r.amplitude[18] ^ fneg_r;
    if (small_r || dig_r.bad) begin
      energy_c = '0;
    end else if (neg_c) begin
      energy_c = (m_c > 35'h0_8000_0000) ? 32'sh8000_0000 : 32'(-m_c);
    end else begin
      energy_c = (m_c > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m_c);
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    pop    = 1'b0;
    emit   = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop    = 1'b1;
          st_nxt = ST_LOG;
        end
      end
      ST_LOG:  st_nxt = ST_LN;
      ST_LN:   st_nxt = ST_FAC;
      ST_FAC:  st_nxt = ST_PROD;
      ST_PROD: st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          emit   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dig_r   <= head;
      mag_r   <= mag_c;
      e_r     <= e_c;
      f_r     <= f_c;
      small_r <= mag_c <= 19'd1;
    end
    if (st_r == ST_LOG)  l2_r <= l2_c;
    if (st_r == ST_LN)   ln_r <= 22'((ln_prod + 64'h8000_0000) >> 32);
    if (st_r == ST_FAC) begin
      fneg_r <= fac_c[24];
      fmag_r <= fac_c[24] ? 23'(-fac_c) : 23'(fac_c);
    end
    if (st_r == ST_PROD) p_r <= 43'(dig_r.gain) * 43'(mag_r);
    if (st_r == ST_MUL) begin
      lo_r <= 55'(p_r[31:0]) * 55'(fmag_r);
      hi_r <= 34'(p_r[42:32]) * 34'(fmag_r);
    end
    if (st_r == ST_SUM) energy_r <= energy_c;
  end

  // background test and event counter
  always_comb begin
    atime   = dig_r.time_fit[15] ? 16'(-dig_r.time_fit) : 16'(dig_r.time_fit);
    hit     = !dig_r.bad && (atime >= 16'(cuts.time_cut))
              && (energy_r >= signed'({1'b0, cuts.energy_cut}));
    cnt_inc = (hit && (cnt_r != COUNT_MAX)) ? cnt_r + 14'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        cnt_r       <= dig_r.last ? 14'd0 : cnt_inc;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cell_r   <= dig_r.bad ? 14'd0 : dig_r.cell_id;
      out_energy_r <= energy_r;
      out_time_r   <= dig_r.time_fit;
      out_err_r    <= dig_r.bad;
      out_done_r   <= dig_r.last;
      out_count_r  <= cnt_inc;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.cell_id_out      = out_cell_r;
  assign out_ch.energy_kev       = out_energy_r;
  assign out_ch.time_out         = out_time_r;
  assign out_ch.cell_error       = out_err_r;
  assign out_ch.event_done       = out_done_r;
  assign out_ch.background_count = out_count_r;

endmodule

// ----- sv/calorimeter_digit_energy_calibrator.sv -----
// ----------------------------------------------------------------------------
// calorimeter_digit_energy_calibrator
// Per-cell energy calibration of calorimeter digits with background counting.
// ----------------------------------------------------------------------------
// digit path: lookup, queue write, pop, six sequencer steps, output register
// the back-end sequencer does the log, factor and product steps in turn for
//   one digit at a time, while the queue takes new digits until it is full;
//   loads are written to the memory as they are accepted
// reset: synchronous, clears the counter and the queue and sets the cut
//   registers to their reset values; the coefficient memory is not cleared
//   and must be loaded before use
module calorimeter_digit_energy_calibrator import caldec_pkg::*; #(
  parameter int CELL_COUNT     = 8736,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  caldec_in_if.sink    in_ch,
  caldec_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  cuts_t             cuts_r;
  logic              push;
  digit_t            push_data;
  logic              pop;
  digit_t            head;
  logic              head_valid;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cuts_r.energy_cut <= ENERGY_CUT_RESET;
      cuts_r.time_cut   <= TIME_CUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENERGY_CUT: cuts_r.energy_cut <= cfg_data;
        REG_TIME_CUT:   cuts_r.time_cut   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  caldec_front #(.CELL_COUNT(CELL_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  caldec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  caldec_back #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cuts       (cuts_r),
    .out_ch     (out_ch)
  );

endmodule
